// ===== sv/srf_pkg.sv =====
package srf_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_COUNT = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] CFG_CONTACT_RADIUS = 2'd0;
    localparam logic [1:0] CFG_INVERSE_SCALE  = 2'd1;
    localparam logic [1:0] CFG_FORCE_GAIN     = 2'd2;

    localparam int MUL_W = 33;
    localparam int REM_W = 64;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         segment_index;
        logic               endpoint_select;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [23:0]        probe_radius;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic [5:0]         contact_count;
    } out_item_t;

endpackage

// ===== sv/segment_repulsion_force_core.sv =====
// Endpoint write and segment count write give no result.
// Query: per segment a load, the 24-step projection division where the projection
// falls inside the segment, and per contacting segment up to three 31-step force
// divisions (one shared division step unit, one shared multiplier), then the mean.
// One item is in work at a time; a finished result waits in the output register.
// Reset (asynchronous, active low) clears the segment count and loads unit registers.
module segment_repulsion_force_core
    import srf_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH  = MAX_SEGMENTS * 6;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = 34 + CNT_W;
    localparam int T_BITS = 24;
    localparam int F_BITS = 31;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_WRITE  = 5'd1;
    localparam logic [4:0] S_SETUP  = 5'd2;
    localparam logic [4:0] S_LOAD   = 5'd3;
    localparam logic [4:0] S_DIFF   = 5'd4;
    localparam logic [4:0] S_DOT    = 5'd5;
    localparam logic [4:0] S_DECIDE = 5'd6;
    localparam logic [4:0] S_TDIV   = 5'd7;
    localparam logic [4:0] S_PROJ   = 5'd8;
    localparam logic [4:0] S_DIST   = 5'd9;
    localparam logic [4:0] S_CHECK  = 5'd10;
    localparam logic [4:0] S_FNUM   = 5'd11;
    localparam logic [4:0] S_FDIV   = 5'd12;
    localparam logic [4:0] S_FADD   = 5'd13;
    localparam logic [4:0] S_NEXT   = 5'd14;
    localparam logic [4:0] S_AVGI   = 5'd15;
    localparam logic [4:0] S_AVGD   = 5'd16;
    localparam logic [4:0] S_AVGS   = 5'd17;
    localparam logic [4:0] S_OUT    = 5'd18;

    logic [4:0]              state_reg;
    logic                    ph_reg;
    logic                    pass_reg;
    logic [1:0]              axis_reg;
    logic [5:0]              step_reg;
    logic [CNT_W-1:0]        seg_reg;
    logic [CNT_W-1:0]        active_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [ADDR_W-1:0]       base_reg;
    logic [ADDR_W-1:0]       wbase_reg;
    logic [23:0]             radius_reg;
    logic [31:0]             inv_reg;
    logic [31:0]             gain_reg;
    logic                    out_valid_reg;
    out_item_t               out_reg;
    in_item_t                item_reg;

    logic [31:0]             c_reg;
    logic [REM_W-1:0]        limit_reg;
    logic [31:0]             coord_reg [6];
    logic signed [29:0]      v_reg [3];
    logic signed [29:0]      w_reg [3];
    logic signed [29:0]      wb_reg [3];
    logic signed [31:0]      d_reg [3];
    logic signed [63:0]      dot_reg;
    logic signed [63:0]      len2_reg;
    logic [REM_W-1:0]        dist2_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [SUM_W-1:0]        sh_reg;
    logic [SUM_W-1:0]        q_reg;
    logic [31:0]             mag_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic signed [31:0]      res_reg [3];

    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [2*MUL_W-1:0] prod;
    logic [REM_W-1:0]          div_den;
    logic                      div_shin;
    logic [REM_W-1:0]          div_rem;
    logic                      div_q;
    logic [SUM_W-1:0]          q_next;
    logic [31:0]               mem_rdata;
    logic [ADDR_W-1:0]         mem_raddr;
    logic                      mem_we;
    logic [31:0]               mem_wdata;

    logic signed [31:0]      p_arr [3];
    logic signed [29:0]      v_sel;
    logic signed [29:0]      w_sel;
    logic signed [31:0]      d_sel;
    logic signed [SUM_W-1:0] sum_sel;
    logic signed [MUL_W-1:0] d_ext;
    logic signed [MUL_W-1:0] d_abs;
    logic [24:0]             rsum;
    logic [31:0]             prod_sat;
    logic [63:0]             num;
    logic                    fsat;
    logic signed [32:0]      term;
    logic [SUM_W-1:0]        sum_abs;
    logic [31:0]             avg_val;

    srf_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    srf_div_step u_div (
        .rem     (rem_reg),
        .shin    (div_shin),
        .den     (div_den),
        .rem_out (div_rem),
        .qbit    (div_q)
    );

    srf_seg_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(wbase_reg + ADDR_W'(axis_reg))),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        p_arr[0] = item_reg.coord_x;
        p_arr[1] = item_reg.coord_y;
        p_arr[2] = item_reg.coord_z;
        v_sel    = v_reg[axis_reg];
        w_sel    = w_reg[axis_reg];
        d_sel    = d_reg[axis_reg];
        sum_sel  = sum_reg[axis_reg];
        d_ext    = MUL_W'(d_sel);
        d_abs    = d_sel[31] ? -d_ext : d_ext;
        rsum     = 25'(radius_reg) + 25'(item_reg.probe_radius);
        prod_sat = (prod[65:48] != 18'd0) ? 32'hFFFF_FFFF : prod[47:16];
        num      = prod[63:0];
        fsat     = (dist2_reg[63:46] == 18'd0) && (num >= {dist2_reg[45:0], 18'd0});
        term     = d_sel[31] ? -{1'b0, mag_reg} : {1'b0, mag_reg};
        sum_abs  = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
        q_next   = {q_reg[SUM_W-2:0], div_q};
        mem_we   = (state_reg == S_WRITE);
        mem_raddr = ADDR_W'(base_reg + ADDR_W'(step_reg[2:0]));
        mem_wdata = p_arr[axis_reg];
        if (sum_sel[SUM_W-1])
        begin
            avg_val = (q_reg > SUM_W'(32'h8000_0000)) ? 32'h8000_0000 : -q_reg[31:0];
        end
        else
        begin
            avg_val = (q_reg > SUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_reg[31:0];
        end
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SETUP:
            begin
                case (step_reg[1:0])
                    2'd0:
                    begin
                        mul_a = MUL_W'(item_reg.probe_radius);
                        mul_b = {1'b0, inv_reg};
                    end
                    2'd1:
                    begin
                        mul_a = {1'b0, c_reg};
                        mul_b = {1'b0, gain_reg};
                    end
                    default:
                    begin
                        mul_a = MUL_W'(rsum);
                        mul_b = MUL_W'(rsum);
                    end
                endcase
            end
            S_DOT:
            begin
                mul_a = MUL_W'(v_sel);
                mul_b = pass_reg ? MUL_W'(v_sel) : MUL_W'(w_sel);
            end
            S_PROJ:
            begin
                mul_a = MUL_W'(q_reg[T_BITS-1:0]);
                mul_b = MUL_W'(v_sel);
            end
            S_DIST:
            begin
                mul_a = d_ext;
                mul_b = d_ext;
            end
            S_FNUM:
            begin
                mul_a = d_abs;
                mul_b = {1'b0, c_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_TDIV:
            begin
                div_den  = REM_W'(len2_reg);
                div_shin = 1'b0;
            end
            S_FDIV:
            begin
                div_den  = dist2_reg;
                div_shin = sh_reg[SUM_W-1];
            end
            default:
            begin
                div_den  = REM_W'(count_reg);
                div_shin = sh_reg[SUM_W-1];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ph_reg        <= 1'b0;
            pass_reg      <= 1'b0;
            axis_reg      <= 2'd0;
            step_reg      <= 6'd0;
            seg_reg       <= '0;
            active_reg    <= '0;
            count_reg     <= '0;
            base_reg      <= '0;
            radius_reg    <= 24'd65536;
            inv_reg       <= 32'd65536;
            gain_reg      <= 32'd65536;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CONTACT_RADIUS: radius_reg <= cfg_data[23:0];
                    CFG_INVERSE_SCALE:  inv_reg    <= cfg_data;
                    CFG_FORCE_GAIN:     gain_reg   <= cfg_data;
                    default:            ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        item_reg  <= in_item;
                        axis_reg  <= 2'd0;
                        step_reg  <= 6'd0;
                        ph_reg    <= 1'b0;
                        wbase_reg <= ADDR_W'(32'(in_item.segment_index) * 6
                                             + 32'(in_item.endpoint_select) * 3);
                        case (in_item.operation)
                            OP_WRITE:
                            begin
                                if (32'(in_item.segment_index) < MAX_SEGMENTS)
                                begin
                                    state_reg <= S_WRITE;
                                end
                            end
                            OP_COUNT:
                            begin
                                if (32'(in_item.segment_index) > MAX_SEGMENTS)
                                begin
                                    active_reg <= CNT_W'(MAX_SEGMENTS);
                                end
                                else
                                begin
                                    active_reg <= CNT_W'(in_item.segment_index);
                                end
                            end
                            OP_QUERY:
                            begin
                                state_reg  <= S_SETUP;
                                seg_reg    <= '0;
                                base_reg   <= '0;
                                count_reg  <= '0;
                                sum_reg[0] <= '0;
                                sum_reg[1] <= '0;
                                sum_reg[2] <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                S_WRITE:
                begin
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_SETUP:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        step_reg <= step_reg + 6'd1;
                        case (step_reg[1:0])
                            2'd0:    c_reg <= prod_sat;
                            2'd1:    c_reg <= prod_sat;
                            default:
                            begin
                                limit_reg <= (prod[63:0] + 64'd63) >> 6;
                                step_reg  <= 6'd0;
                                state_reg <= (active_reg == '0) ? S_AVGI : S_LOAD;
                            end
                        endcase
                    end
                end

                S_LOAD:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg != 6'd0)
                    begin
                        coord_reg[3'(step_reg - 6'd1)] <= mem_rdata;
                    end
                    if (step_reg == 6'd6)
                    begin
                        state_reg <= S_DIFF;
                    end
                end

                S_DIFF:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        v_reg[j]  <= 30'((33'(signed'(coord_reg[j+3]))
                                          - 33'(signed'(coord_reg[j]))) >>> 3);
                        w_reg[j]  <= 30'((33'(p_arr[j])
                                          - 33'(signed'(coord_reg[j]))) >>> 3);
                        wb_reg[j] <= 30'((33'(p_arr[j])
                                          - 33'(signed'(coord_reg[j+3]))) >>> 3);
                    end
                    dot_reg   <= '0;
                    len2_reg  <= '0;
                    axis_reg  <= 2'd0;
                    pass_reg  <= 1'b0;
                    ph_reg    <= 1'b0;
                    state_reg <= S_DOT;
                end

                S_DOT:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        if (pass_reg)
                        begin
                            len2_reg <= len2_reg + prod[63:0];
                        end
                        else
                        begin
                            dot_reg <= dot_reg + prod[63:0];
                        end
                        axis_reg <= axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                        begin
                            axis_reg <= 2'd0;
                            pass_reg <= 1'b1;
                            if (pass_reg)
                            begin
                                state_reg <= S_DECIDE;
                            end
                        end
                    end
                end

                S_DECIDE:
                begin
                    dist2_reg <= '0;
                    rem_reg   <= REM_W'(dot_reg);
                    q_reg     <= '0;
                    step_reg  <= 6'd0;
                    axis_reg  <= 2'd0;
                    if (len2_reg > 0 && dot_reg >= len2_reg)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            d_reg[j] <= 32'(wb_reg[j]);
                        end
                        state_reg <= S_DIST;
                    end
                    else if (len2_reg > 0 && dot_reg > 0)
                    begin
                        state_reg <= S_TDIV;
                    end
                    else
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            d_reg[j] <= 32'(w_reg[j]);
                        end
                        state_reg <= S_DIST;
                    end
                end

                S_TDIV:
                begin
                    rem_reg  <= div_rem;
                    q_reg    <= q_next;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(T_BITS - 1))
                    begin
                        state_reg <= S_PROJ;
                    end
                end

                S_PROJ:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        d_reg[axis_reg] <= 32'(w_sel) - 32'(prod >>> T_BITS);
                        axis_reg <= axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                        begin
                            axis_reg  <= 2'd0;
                            state_reg <= S_DIST;
                        end
                    end
                end

                S_DIST:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        dist2_reg <= dist2_reg + prod[63:0];
                        axis_reg  <= axis_reg + 2'd1;
                        if (axis_reg == 2'd2)
                        begin
                            axis_reg  <= 2'd0;
                            state_reg <= S_CHECK;
                        end
                    end
                end

                S_CHECK:
                begin
                    if (dist2_reg < limit_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= (dist2_reg != '0) ? S_FNUM : S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_NEXT;
                    end
                end

                S_FNUM:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        step_reg <= 6'd0;
                        if (fsat)
                        begin
                            mag_reg   <= d_sel[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                            state_reg <= S_FADD;
                        end
                        else
                        begin
                            rem_reg   <= REM_W'(num[63:18]);
                            sh_reg    <= {num[17:0], {(SUM_W-18){1'b0}}};
                            q_reg     <= '0;
                            state_reg <= S_FDIV;
                        end
                    end
                end

                S_FDIV:
                begin
                    rem_reg  <= div_rem;
                    q_reg    <= q_next;
                    sh_reg   <= sh_reg << 1;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(F_BITS - 1))
                    begin
                        mag_reg   <= q_next[31:0];
                        state_reg <= S_FADD;
                    end
                end

                S_FADD:
                begin
                    sum_reg[axis_reg] <= sum_sel + SUM_W'(term);
                    axis_reg <= axis_reg + 2'd1;
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg  <= 2'd0;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_FNUM;
                    end
                end

                S_NEXT:
                begin
                    step_reg <= 6'd0;
                    axis_reg <= 2'd0;
                    if ((CNT_W+1)'(seg_reg) + 1'b1 < (CNT_W+1)'(active_reg))
                    begin
                        seg_reg   <= seg_reg + 1'b1;
                        base_reg  <= ADDR_W'(base_reg + ADDR_W'(6));
                        state_reg <= S_LOAD;
                    end
                    else
                    begin
                        state_reg <= S_AVGI;
                    end
                end

                S_AVGI:
                begin
                    step_reg <= 6'd0;
                    if (count_reg == '0)
                    begin
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        res_reg[2] <= '0;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        sh_reg    <= sum_abs;
                        state_reg <= S_AVGD;
                    end
                end

                S_AVGD:
                begin
                    rem_reg  <= div_rem;
                    q_reg    <= q_next;
                    sh_reg   <= sh_reg << 1;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(SUM_W - 1))
                    begin
                        state_reg <= S_AVGS;
                    end
                end

                S_AVGS:
                begin
                    res_reg[axis_reg] <= avg_val;
                    axis_reg <= axis_reg + 2'd1;
                    state_reg <= (axis_reg == 2'd2) ? S_OUT : S_AVGI;
                end

                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.force_x       <= res_reg[0];
                        out_reg.force_y       <= res_reg[1];
                        out_reg.force_z       <= res_reg[2];
                        out_reg.contact_count <= 6'(count_reg);
                        out_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== sv/srf_mul.sv =====
module srf_mul
    import srf_pkg::*;
(
    input  logic                          clk,
    input  logic signed [MUL_W-1:0]       a,
    input  logic signed [MUL_W-1:0]       b,
    output logic signed [2*MUL_W-1:0]     prod
);

    logic signed [2*MUL_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// ===== sv/srf_div_step.sv =====
module srf_div_step
    import srf_pkg::*;
(
    input  logic [REM_W-1:0] rem,
    input  logic             shin,
    input  logic [REM_W-1:0] den,
    output logic [REM_W-1:0] rem_out,
    output logic             qbit
);

    logic [REM_W:0] trial;
    logic [REM_W:0] diff;

    always_comb
    begin
        trial   = {rem, shin};
        diff    = trial - {1'b0, den};
        qbit    = (trial >= {1'b0, den});
        rem_out = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end

endmodule

// ===== sv/srf_seg_mem.sv =====
module srf_seg_mem #(
    parameter int DEPTH  = 192,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
